/* rtl/mrtlf_pkg.sv */
// ----------------------------------------------------------------------------
// mrtlf_pkg
// Shared widths, constants and controller/datapath interface types for the
// multi-route tour length and fitness block.
// ----------------------------------------------------------------------------
package mrtlf_pkg;

    // coordinate and fixed-point format
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int SUM_W      = 32;
    localparam int FIT_W      = 40;

    // depot register reset and configuration map
    localparam int DEPOT_RESET = 500;
    localparam int CFG_W       = 32;
    localparam int REG_COUNT   = 2;
    localparam int ADDR_W      = $clog2(4 * REG_COUNT);
    localparam int REG_IDX_W   = ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEPOT_X = 1'b0,
        REG_DEPOT_Y = 1'b1
    } reg_idx_t;

    // squared distance and square root sizing
    localparam int SQ_W     = 2 * COORD_BITS + 1;
    localparam int ROOT_W   = (SQ_W + 1) / 2 + FRAC_BITS;
    localparam int ITERS    = (ROOT_W + 1) / 2;
    localparam int RT_W     = 2 * ITERS;
    localparam int RAD_W    = 4 * ITERS;
    localparam int REM_W    = RT_W + 3;

    // fitness division sizing
    localparam int FIT_NUM     = 10000;
    localparam int FIT_NUM_W   = $clog2(FIT_NUM + 1);
    localparam int FIT_SHIFT   = FRAC_BITS + 16;
    localparam int FIT_DIV_W   = FIT_NUM_W + FIT_SHIFT;
    localparam int FIT_CMP_W   = (FIT_DIV_W > FIT_W) ? FIT_DIV_W : FIT_W;

    typedef logic [FIT_DIV_W-1:0] fit_div_t;
    localparam fit_div_t FIT_DIVIDEND = fit_div_t'(FIT_NUM) << FIT_SHIFT;
    localparam logic [FIT_W-1:0] FIT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // sequencer counter
    localparam int CNT_MAX = (ITERS > FIT_DIV_W) ? ITERS : FIT_DIV_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic square;
        logic rad_load;
        logic root_step;
        logic accum;
        logic div_init;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

/* rtl/multi_route_tour_length_fitness.sv */
// ----------------------------------------------------------------------------
// multi_route_tour_length_fitness
// Sums Euclidean leg lengths of a multi-route tour city by city and gives
// the total length and its fitness on the last city of the tour.
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  s_*       in         city_x, city_y (tdata); route_first (tuser); tour_last (tlast)
//  m_*       out        total_distance, fitness (tdata); overflow_flag (tuser)
//  apb       in/out     depot_x at 0x0, depot_y at 0x4
//
//  A city word goes through difference, square, root load, 11 radix-4
//  square root iterations and accumulate, in that order.
//  The last city of a tour then goes through divider load, a 38-step
//  restoring division for fitness, and the handoff into the output register.
//  The handoff waits while the output register still holds an untaken word;
//  the input side is ready again right after it.
//  Reset is synchronous and active low; depot registers reset to 500.
// ----------------------------------------------------------------------------
module multi_route_tour_length_fitness (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input city words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // city_x[11:0], city_y[23:12]
    input  logic                          s_tuser,  // route_first
    input  logic                          s_tlast,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,  // total_distance[31:0], fitness[71:32]
    output logic                          m_tuser,  // overflow_flag
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrtlf_pkg::ADDR_W-1:0]  paddr,
    input  logic [mrtlf_pkg::CFG_W-1:0]   pwdata,
    output logic [mrtlf_pkg::CFG_W-1:0]   prdata,
    output logic                          pready
);
    import mrtlf_pkg::*;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [COORD_BITS-1:0] depot_x_reg, depot_y_reg;
    logic [SUM_W-1:0]      total_distance;
    logic [FIT_W-1:0]      fitness;
    logic                  overflow_flag;
    logic                  cfg_write;
    reg_idx_t              reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    // depot registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depot_x_reg <= COORD_BITS'(DEPOT_RESET);
            depot_y_reg <= COORD_BITS'(DEPOT_RESET);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_DEPOT_X: depot_x_reg <= pwdata[COORD_BITS-1:0];
                REG_DEPOT_Y: depot_y_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_DEPOT_X: prdata = CFG_W'(depot_x_reg);
            REG_DEPOT_Y: prdata = CFG_W'(depot_y_reg);
            default:     prdata = '0;
        endcase
    end

    mrtlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mrtlf_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .depot_x        (depot_x_reg),
        .depot_y        (depot_y_reg),
        .city_x         (s_tdata[11:0]),
        .city_y         (s_tdata[23:12]),
        .route_first    (s_tuser),
        .tour_last      (s_tlast),
        .total_distance (total_distance),
        .fitness        (fitness),
        .overflow_flag  (overflow_flag)
    );

    // result word packing
    assign m_tdata = {fitness, total_distance};
    assign m_tuser = overflow_flag;

endmodule

/* rtl/mrtlf_ctrl.sv */
// ----------------------------------------------------------------------------
// mrtlf_ctrl
// Sequencer: steps each city word through difference, squaring, the radix-4
// square root and accumulation, then runs the fitness division on the last
// city and hands the result to the output register.
// ----------------------------------------------------------------------------
module mrtlf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mrtlf_pkg::dp_cmd_t  cmd,
    input  mrtlf_pkg::dp_stat_t stat
);
    import mrtlf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_LOAD,
        S_ROOT,
        S_ACCUM,
        S_DINIT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.rad_load = 1'b1;
                cnt_next     = CNT_W'(ITERS - 1);
                state_next   = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = stat.last ? S_DINIT : S_IDLE;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = CNT_W'(FIT_DIV_W - 1);
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* rtl/mrtlf_dp.sv */
// ----------------------------------------------------------------------------
// mrtlf_dp
// Datapath: coordinate differences, squares, a two-bit-per-cycle square root,
// the saturating distance sum, a restoring divider for fitness and the
// output register.
// ----------------------------------------------------------------------------
module mrtlf_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrtlf_pkg::dp_cmd_t            cmd,
    output mrtlf_pkg::dp_stat_t           stat,
    input  logic [mrtlf_pkg::COORD_BITS-1:0] depot_x,
    input  logic [mrtlf_pkg::COORD_BITS-1:0] depot_y,
    input  logic [mrtlf_pkg::COORD_BITS-1:0] city_x,
    input  logic [mrtlf_pkg::COORD_BITS-1:0] city_y,
    input  logic                          route_first,
    input  logic                          tour_last,
    output logic [mrtlf_pkg::SUM_W-1:0]   total_distance,
    output logic [mrtlf_pkg::FIT_W-1:0]   fitness,
    output logic                          overflow_flag
);
    import mrtlf_pkg::*;

    localparam int DIFF_SQ_W = 2 * COORD_BITS;

    // tour state
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  tour_start_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  sat_reg, sat_next;

    // per-city working registers
    logic                  last_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [DIFF_SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [RT_W-1:0]       root_reg, root_next;

    // divider registers
    logic [FIT_DIV_W-1:0]  quo_reg, quo_next;
    logic [SUM_W-1:0]      drem_reg, drem_next;

    // output register
    logic [SUM_W-1:0]      out_total_reg;
    logic [FIT_W-1:0]      out_fit_reg, fit_value;
    logic                  out_flag_reg;

    logic [COORD_BITS-1:0] from_x, from_y;
    logic [SQ_W-1:0]       sq_sum;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W:0]        div_trial;
    logic [FIT_CMP_W-1:0]  quo_ext;
    logic                  sum_zero;

    assign stat.last      = last_reg;
    assign total_distance = out_total_reg;
    assign fitness        = out_fit_reg;
    assign overflow_flag  = out_flag_reg;

    // start point and absolute differences
    always_comb begin
        if (route_first || tour_start_reg) begin
            from_x = depot_x;
            from_y = depot_y;
        end else begin
            from_x = prev_x_reg;
            from_y = prev_y_reg;
        end
        dx_next = (city_x >= from_x) ? city_x - from_x : from_x - city_x;
        dy_next = (city_y >= from_y) ? city_y - from_y : from_y - city_y;
    end

    assign sq_sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    // two root bits per cycle
    always_comb begin
        logic [REM_W-1:0] r;
        logic [RT_W-1:0]  q;
        logic [REM_W-1:0] trial;
        r = rem_reg;
        q = root_reg;
        for (int k = 0; k < 2; k++) begin
            r     = {r[REM_W-3:0], rad_reg[RAD_W-1-2*k -: 2]};
            trial = {1'b0, q, 2'b01};
            if (r >= trial) begin
                r = r - trial;
                q = {q[RT_W-2:0], 1'b1};
            end else begin
                q = {q[RT_W-2:0], 1'b0};
            end
        end
        rem_next  = r;
        root_next = q;
    end

    // saturating accumulation
    always_comb begin
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(root_reg);
        if (sum_wide[SUM_W]) begin
            sum_next = SUM_MAX;
            sat_next = 1'b1;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
            sat_next = sat_reg;
        end
    end

    // restoring division step
    always_comb begin
        div_trial = {drem_reg, quo_reg[FIT_DIV_W-1]};
        if (div_trial >= {1'b0, sum_reg}) begin
            drem_next = SUM_W'(div_trial - {1'b0, sum_reg});
            quo_next  = {quo_reg[FIT_DIV_W-2:0], 1'b1};
        end else begin
            drem_next = div_trial[SUM_W-1:0];
            quo_next  = {quo_reg[FIT_DIV_W-2:0], 1'b0};
        end
    end

    // fitness clipping and zero total
    always_comb begin
        sum_zero = (sum_reg == '0);
        quo_ext  = FIT_CMP_W'(quo_reg);
        if (sum_zero || (quo_ext > FIT_CMP_W'(FIT_MAX))) begin
            fit_value = FIT_MAX;
        end else begin
            fit_value = FIT_W'(quo_ext);
        end
    end

    // tour state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            tour_start_reg <= 1'b1;
            sum_reg        <= '0;
            sat_reg        <= 1'b0;
        end else begin
            if (cmd.capture) begin
                prev_x_reg     <= city_x;
                prev_y_reg     <= city_y;
                tour_start_reg <= 1'b0;
            end
            if (cmd.accum) begin
                sum_reg <= sum_next;
                sat_reg <= sat_next;
            end
            if (cmd.emit) begin
                sum_reg        <= '0;
                sat_reg        <= 1'b0;
                tour_start_reg <= 1'b1;
            end
        end
    end

    // working and output registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            last_reg <= tour_last;
        end
        if (cmd.square) begin
            sqx_reg <= DIFF_SQ_W'(dx_reg) * DIFF_SQ_W'(dx_reg);
            sqy_reg <= DIFF_SQ_W'(dy_reg) * DIFF_SQ_W'(dy_reg);
        end
        if (cmd.rad_load) begin
            rad_reg  <= RAD_W'(sq_sum) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step) begin
            rad_reg  <= rad_reg << 4;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.div_init) begin
            quo_reg  <= FIT_DIVIDEND;
            drem_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg  <= quo_next;
            drem_reg <= drem_next;
        end
        if (cmd.emit) begin
            out_total_reg <= sum_reg;
            out_fit_reg   <= fit_value;
            out_flag_reg  <= sat_reg || sum_zero;
        end
    end

endmodule

/* bench/multi_route_tour_length_fitness_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_route_tour_length_fitness_checker
// Watches the city, result and configuration ports of the tour length block.
// Keeps its own copy of the depot registers and the running tour state,
// predicts the total length and fitness of every finished tour, and checks
// each result word against the oldest predicted tour.
// ----------------------------------------------------------------------------
module multi_route_tour_length_fitness_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // city_x[11:0], city_y[23:12]
    input  logic                           s_tuser,   // route_first
    input  logic                           s_tlast,   // tour_last
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [71:0]                    m_tdata,   // total_distance[31:0], fitness[71:32]
    input  logic                           m_tuser,   // overflow_flag
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrtlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [mrtlf_pkg::CFG_W-1:0]    pwdata,
    input  logic                           pready,
    output int                             error_count,
    output int                             pending_tours
);
    import mrtlf_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [FIT_W-1:0] fitness;
        logic             overflow;
    } tour_score_t;

    tour_score_t             tour_scores_q[$];
    logic [COORD_BITS-1:0]   cfg_depot_x;
    logic [COORD_BITS-1:0]   cfg_depot_y;
    logic [COORD_BITS-1:0]   last_x;
    logic [COORD_BITS-1:0]   last_y;
    logic [SUM_W-1:0]        run_sum;
    logic                    from_depot;
    logic                    sum_clipped;
    int                      fail_count;

    // floor of the leg length, scaled by 2^FRAC_BITS, one root bit per pass
    function automatic logic [SUM_W-1:0] leg_length(input logic [COORD_BITS-1:0] dx,
                                                    input logic [COORD_BITS-1:0] dy);
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] probe;
        radicand = (64'(dx) * 64'(dx) + 64'(dy) * 64'(dy)) << (2 * FRAC_BITS);
        root = '0;
        for (int b = 23; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= radicand) begin
                root = probe;
            end
        end
        return root[SUM_W-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] span(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // advance the tour state by one city, queue a score on the last city
    function automatic void track_city(input logic [COORD_BITS-1:0] cx,
                                       input logic [COORD_BITS-1:0] cy,
                                       input logic route_first,
                                       input logic tour_last);
        logic [COORD_BITS-1:0] ox;
        logic [COORD_BITS-1:0] oy;
        logic [SUM_W:0]        grown;
        logic [63:0]           quotient;
        tour_score_t           score;
        ox = (route_first || from_depot) ? cfg_depot_x : last_x;
        oy = (route_first || from_depot) ? cfg_depot_y : last_y;
        grown = {1'b0, run_sum} + {1'b0, leg_length(span(cx, ox), span(cy, oy))};
        if (grown[SUM_W]) begin
            run_sum     = SUM_MAX;
            sum_clipped = 1'b1;
        end else begin
            run_sum = grown[SUM_W-1:0];
        end
        last_x     = cx;
        last_y     = cy;
        from_depot = 1'b0;
        if (tour_last) begin
            score.total    = run_sum;
            score.overflow = sum_clipped;
            if (run_sum == '0) begin
                score.fitness  = FIT_MAX;
                score.overflow = 1'b1;
            end else begin
                quotient = (64'(FIT_NUM) << FIT_SHIFT) / 64'(run_sum);
                score.fitness = (quotient > 64'(FIT_MAX)) ? FIT_MAX : quotient[FIT_W-1:0];
            end
            tour_scores_q.push_back(score);
            run_sum     = '0;
            sum_clipped = 1'b0;
            from_depot  = 1'b1;
        end
    endfunction

    function automatic void report_miss(input string what, input tour_score_t want,
                                        input tour_score_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected total %h fitness %h flag %b, %s %h fitness %h flag %b",
                     $realtime, what, want.total, want.fitness, want.overflow,
                     "got total", got.total, got.fitness, got.overflow);
        end
    endfunction

    // snoop config writes, city words and result words at each edge
    always @(posedge aclk) begin
        tour_score_t got;
        tour_score_t want;
        if (!aresetn) begin
            cfg_depot_x = COORD_BITS'(DEPOT_RESET);
            cfg_depot_y = COORD_BITS'(DEPOT_RESET);
            last_x      = '0;
            last_y      = '0;
            run_sum     = '0;
            from_depot  = 1'b1;
            sum_clipped = 1'b0;
            tour_scores_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_DEPOT_X: cfg_depot_x = pwdata[COORD_BITS-1:0];
                    REG_DEPOT_Y: cfg_depot_y = pwdata[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                track_city(s_tdata[11:0], s_tdata[23:12], s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got.total    = m_tdata[31:0];
                got.fitness  = m_tdata[71:32];
                got.overflow = m_tuser;
                if (tour_scores_q.size() == 0) begin
                    report_miss("result word with no tour pending", '0, got);
                end else begin
                    want = tour_scores_q.pop_front();
                    if (got !== want) begin
                        report_miss("tour score mismatch", want, got);
                    end
                end
            end
        end
        pending_tours <= tour_scores_q.size();
        error_count   <= fail_count;
    end

endmodule

/* bench/multi_route_tour_length_fitness_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_route_tour_length_fitness_tb
// Drives city words and depot settings into the tour length block: a short
// directed set of corner cases, random tours under several depot settings,
// a long tour between opposite corners, and back-pressure phases.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_route_tour_length_fitness_tb;
    import mrtlf_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_CITIES  = 160;
    localparam int LONG_TOUR     = 64;
    localparam logic [COORD_BITS-1:0] CMAX = '1;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // city_x[11:0], city_y[23:12]
    logic              s_tuser;   // route_first
    logic              s_tlast;   // tour_last
    logic              m_tvalid;
    logic              m_tready;
    logic [71:0]       m_tdata;   // total_distance[31:0], fitness[71:32]
    logic              m_tuser;   // overflow_flag
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;
    int                error_count;
    int                pending_tours;

    logic              steady;     // no idling on either side
    int                hold_len;   // requested receiver hold-off

    multi_route_tour_length_fitness i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    multi_route_tour_length_fitness_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_tours (pending_tours)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic lull();
        return !steady && ($urandom_range(99) < 37);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CMAX;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                m_tready = 1'b0;
                repeat (n) @(negedge aclk);
            end else begin
                m_tready = !lull();
            end
        end
    end

    // offer one city word and wait for it to be taken
    task automatic send_city(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                             input logic route_first, input logic tour_last);
        @(negedge aclk);
        while (lull()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {cy, cx};
        s_tuser  = route_first;
        s_tlast  = tour_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // let every pending tour come out and the block go quiet
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_tours == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // setup and access cycles; upper data bits are random junk
    task automatic write_reg(input reg_idx_t idx, input logic [COORD_BITS-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = {(CFG_W - COORD_BITS)'($urandom), value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_depot(input logic [COORD_BITS-1:0] dx, input logic [COORD_BITS-1:0] dy);
        write_reg(REG_DEPOT_X, dx);
        write_reg(REG_DEPOT_Y, dy);
    endtask

    // random tours, mostly short, now and then a long one or a full pause
    task automatic random_tours(input int n_cities);
        int   sent;
        int   len;
        logic route_first;
        sent = 0;
        while (sent < n_cities) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            if ($urandom_range(29) == 0) begin
                drain();
            end
            for (int k = 0; k < len; k++) begin
                route_first = (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(4) == 0);
                send_city(pick_coord(), pick_coord(), route_first, k == len - 1);
            end
            sent += len;
        end
    endtask

    // stimulus and verdict
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 1'b0;
        hold_len = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset depot: zero-length tour with route start and tour end together
        send_city(COORD_BITS'(DEPOT_RESET), COORD_BITS'(DEPOT_RESET), 1'b1, 1'b1);
        // first city after a tour starts at the depot even without route_first
        send_city('0, '0, 1'b0, 1'b0);
        send_city(CMAX, CMAX, 1'b0, 1'b0);
        send_city(CMAX, '0, 1'b1, 1'b0);
        send_city('0, CMAX, 1'b0, 1'b1);
        send_city(CMAX, CMAX, 1'b0, 1'b1);
        drain();

        // depot at the origin
        set_depot('0, '0);
        send_city('0, '0, 1'b1, 1'b1);
        send_city(CMAX, CMAX, 1'b0, 1'b0);
        send_city(CMAX, CMAX, 1'b0, 1'b0);
        send_city('0, '0, 1'b0, 1'b1);
        send_city(12'd1, '0, 1'b1, 1'b1);
        send_city('0, 12'd1, 1'b0, 1'b0);
        send_city(12'd1, 12'd1, 1'b0, 1'b1);
        drain();

        // depot at the far corner
        set_depot(CMAX, CMAX);
        send_city('0, '0, 1'b0, 1'b1);
        send_city(CMAX, CMAX, 1'b1, 1'b0);
        send_city(CMAX, CMAX - 12'd1, 1'b1, 1'b0);
        send_city(12'haaa, 12'h555, 1'b0, 1'b1);
        send_city(12'h555, 12'haaa, 1'b1, 1'b1);
        drain();

        // random tours with a random depot
        set_depot(pick_coord(), pick_coord());
        random_tours(PHASE_CITIES);
        drain();

        // long receiver hold-off while cities keep coming
        set_depot(COORD_BITS'($urandom), COORD_BITS'($urandom));
        hold_len = HOLD_CYCLES;
        random_tours(PHASE_CITIES);
        drain();

        // no idling on either side
        set_depot('0, CMAX);
        steady = 1'b1;
        random_tours(PHASE_CITIES);
        drain();

        // one long tour bouncing between opposite corners, then a normal one
        set_depot('0, '0);
        for (int k = 0; k < LONG_TOUR; k++) begin
            send_city((k % 2 == 0) ? CMAX : '0, (k % 2 == 0) ? CMAX : '0, 1'b0,
                      k == LONG_TOUR - 1);
        end
        send_city(CMAX, '0, 1'b1, 1'b0);
        send_city('0, CMAX, 1'b0, 1'b1);
        steady = 1'b0;
        drain();

        set_depot(CMAX, '0);
        random_tours(PHASE_CITIES);
        drain();

        set_depot(COORD_BITS'($urandom), COORD_BITS'($urandom));
        hold_len = HOLD_CYCLES;
        random_tours(PHASE_CITIES);
        drain();

        if (error_count == 0 && pending_tours == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mrtlf_pkg.sv
rtl/mrtlf_ctrl.sv
rtl/mrtlf_dp.sv
rtl/multi_route_tour_length_fitness.sv
bench/multi_route_tour_length_fitness_checker.sv
bench/multi_route_tour_length_fitness_tb.sv
